@@ rtl/huffman_code_table_builder_defines.svh @@
// assertion macros for the huffman code table builder checker
// no dependencies; taken in by `include where assertions are written
`ifndef HUFFMAN_CODE_TABLE_BUILDER_DEFINES_SVH
`define HUFFMAN_CODE_TABLE_BUILDER_DEFINES_SVH

// concurrent assertion on an explicit clock and reset
`define HCB_ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// concurrent assertion on the block clock and reset
`define HCB_ASSERT(label, prop, msg) `HCB_ASSERT_CLK(label, clock, reset, prop, msg)

`endif

@@ rtl/hcb_pkg.sv @@
// shared constants, codes and helper functions of the huffman code table builder
// no dependencies
package hcb_pkg;

   localparam int MAX_CODE_LENGTH = 16;
   localparam int COUNT_SLOTS     = 16;

   localparam int FUNC_W   = 1;
   localparam int LEN_W    = 5;
   localparam int COUNT_W  = 8;
   localparam int SYM_W    = 8;
   localparam int CODE_W   = 16;
   localparam int NC_W     = 17;
   localparam int STATUS_W = 2;
   localparam int CL_W     = $clog2(MAX_CODE_LENGTH + 2);
   localparam int ADDR_W   = $clog2(COUNT_SLOTS);

   localparam logic [NC_W-1:0] CODE_SAT = {NC_W{1'b1}};

   localparam logic [FUNC_W-1:0] FUNC_COUNT  = 1'b0;
   localparam logic [FUNC_W-1:0] FUNC_SYMBOL = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_TOO_MANY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

   function automatic logic [NC_W-1:0] shl_sat(input logic [NC_W-1:0] v);
      logic [NC_W-1:0] r;
      r = v[NC_W-1] ? CODE_SAT : {v[NC_W-2:0], 1'b0};
      return r;
   endfunction

   function automatic logic [NC_W-1:0] inc_sat(input logic [NC_W-1:0] v);
      logic [NC_W-1:0] r;
      r = (v == CODE_SAT) ? CODE_SAT : v + NC_W'(1);
      return r;
   endfunction

endpackage

@@ rtl/hcb_channels.sv @@
// valid/ready channel interfaces for count/symbol requests and table entry responses
// depends on hcb_pkg
interface hcb_req_if;
   logic                         valid;
   logic                         ready;
   logic [hcb_pkg::FUNC_W-1:0]   func;
   logic [hcb_pkg::LEN_W-1:0]    length;
   logic [hcb_pkg::COUNT_W-1:0]  count;
   logic [hcb_pkg::SYM_W-1:0]    symbol;

   modport source (output valid, func, length, count, symbol, input ready);
   modport sink (input valid, func, length, count, symbol, output ready);
endinterface

interface hcb_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [hcb_pkg::SYM_W-1:0]     symbol_out;
   logic [hcb_pkg::CODE_W-1:0]    code;
   logic [hcb_pkg::LEN_W-1:0]     code_length;
   logic [hcb_pkg::STATUS_W-1:0]  status;

   modport source (output valid, symbol_out, code, code_length, status, input ready);
   modport sink (input valid, symbol_out, code, code_length, status, output ready);
endinterface

@@ rtl/huffman_code_table_builder.sv @@
// top level of the jpeg canonical huffman code table builder
// depends on hcb_pkg and the channel interfaces in hcb_channels.sv
//
// usage:
//   req_ch carries count transfers (func 0: count of codes for one length) and
//   symbol transfers (func 1: next symbol in table order). a count for length 1
//   clears all counts and restarts the code. rsp_ch returns one table entry per
//   symbol transfer: symbol, code, code length and status; count transfers give
//   no response.
// timing:
//   a count transfer is written straight into the count memory. a symbol
//   transfer steps through a read and a check state for each length up to
//   its own, since each length step is one registered read of the count
//   memory and one compare; a symbol beyond the counted total gets status too many.
// reset:
//   synchronous reset clears the per-length valid bits (all counts read as
//   zero), the code state and the response valid bit; no clearing pass.
// stall:
//   the response register holds a finished entry while rsp_ch.ready is low;
//   new transfers are still taken and a following symbol waits only when its
//   own entry is ready and the register is still full.
module huffman_code_table_builder (
   input logic        clock,
   input logic        reset,
   hcb_req_if.sink    req_ch,
   hcb_rsp_if.source  rsp_ch
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_READ  = 2'd1;
   localparam logic [1:0] ST_CHECK = 2'd2;

   logic [1:0]                     state_ff, state_in;
   logic [hcb_pkg::CL_W-1:0]       cl_ff, cl_in;
   logic [hcb_pkg::COUNT_W-1:0]    used_ff, used_in;
   logic [hcb_pkg::NC_W-1:0]       nc_ff, nc_in;
   logic [hcb_pkg::COUNT_SLOTS-1:0] valid_ff, valid_in;
   logic [hcb_pkg::SYM_W-1:0]      sym_ff, sym_in;

   logic [hcb_pkg::COUNT_W-1:0]    mem [hcb_pkg::COUNT_SLOTS];
   logic [hcb_pkg::COUNT_W-1:0]    rd_data_ff;
   logic                           rd_valid_ff;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [hcb_pkg::SYM_W-1:0]      rsp_sym_ff, rsp_sym_in;
   logic [hcb_pkg::CODE_W-1:0]     rsp_code_ff, rsp_code_in;
   logic [hcb_pkg::LEN_W-1:0]      rsp_len_ff, rsp_len_in;
   logic [hcb_pkg::STATUS_W-1:0]   rsp_status_ff, rsp_status_in;

   logic                           accept;
   logic                           cnt_wr;
   logic [hcb_pkg::ADDR_W-1:0]     wr_addr;
   logic [hcb_pkg::ADDR_W-1:0]     rd_addr;
   logic [hcb_pkg::LEN_W-1:0]      len_m1;
   logic [hcb_pkg::CL_W-1:0]       cl_m1;
   logic [hcb_pkg::COUNT_W-1:0]    cnt_eff;
   logic                           out_free;
   logic                           emit;
   logic                           past_max;
   logic                           overflow;

   assign accept   = req_ch.valid && req_ch.ready;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign len_m1   = req_ch.length - hcb_pkg::LEN_W'(1);
   assign wr_addr  = len_m1[hcb_pkg::ADDR_W-1:0];
   assign cl_m1    = cl_ff - hcb_pkg::CL_W'(1);
   assign rd_addr  = cl_m1[hcb_pkg::ADDR_W-1:0];
   assign cnt_wr   = accept && (req_ch.func == hcb_pkg::FUNC_COUNT) &&
                     (req_ch.length != '0) &&
                     (req_ch.length <= hcb_pkg::LEN_W'(hcb_pkg::MAX_CODE_LENGTH));
   assign cnt_eff  = rd_valid_ff ? rd_data_ff : '0;
   assign past_max = cl_ff > hcb_pkg::CL_W'(hcb_pkg::MAX_CODE_LENGTH);
   assign overflow = (nc_ff >> cl_ff) != '0;

   assign req_ch.ready       = (state_ff == ST_IDLE);
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.symbol_out  = rsp_sym_ff;
   assign rsp_ch.code        = rsp_code_ff;
   assign rsp_ch.code_length = rsp_len_ff;
   assign rsp_ch.status      = rsp_status_ff;

   always_comb begin
      state_in      = state_ff;
      cl_in         = cl_ff;
      used_in       = used_ff;
      nc_in         = nc_ff;
      valid_in      = valid_ff;
      sym_in        = sym_ff;
      emit          = 1'b0;
      rsp_sym_in    = rsp_sym_ff;
      rsp_code_in   = rsp_code_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_status_in = rsp_status_ff;

      case (state_ff)
         ST_IDLE: begin
            if (cnt_wr) begin
               if (req_ch.length == hcb_pkg::LEN_W'(1)) begin
                  valid_in = '0;
                  cl_in    = hcb_pkg::CL_W'(1);
                  used_in  = '0;
                  nc_in    = '0;
               end
               valid_in[wr_addr] = 1'b1;
            end
            if (accept && (req_ch.func == hcb_pkg::FUNC_SYMBOL)) begin
               sym_in   = req_ch.symbol;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (past_max) begin
               if (out_free) begin
                  emit          = 1'b1;
                  rsp_sym_in    = sym_ff;
                  rsp_code_in   = '0;
                  rsp_len_in    = '0;
                  rsp_status_in = hcb_pkg::STATUS_TOO_MANY;
                  state_in      = ST_IDLE;
               end
            end else begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (used_ff >= cnt_eff) begin
               nc_in    = hcb_pkg::shl_sat(nc_ff);
               cl_in    = cl_ff + hcb_pkg::CL_W'(1);
               used_in  = '0;
               state_in = ST_READ;
            end else if (out_free) begin
               emit       = 1'b1;
               rsp_sym_in = sym_ff;
               if (overflow) begin
                  rsp_code_in   = '0;
                  rsp_len_in    = '0;
                  rsp_status_in = hcb_pkg::STATUS_OVERFLOW;
               end else begin
                  rsp_code_in   = nc_ff[hcb_pkg::CODE_W-1:0];
                  rsp_len_in    = hcb_pkg::LEN_W'(cl_ff);
                  rsp_status_in = hcb_pkg::STATUS_OK;
               end
               nc_in    = hcb_pkg::inc_sat(nc_ff);
               used_in  = used_ff + hcb_pkg::COUNT_W'(1);
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = emit || (rsp_valid_ff && !rsp_ch.ready);
   end

   // count memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cnt_wr) begin
         mem[wr_addr] <= req_ch.count;
      end
      rd_data_ff  <= mem[rd_addr];
      rd_valid_ff <= valid_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cl_ff        <= hcb_pkg::CL_W'(1);
         used_ff      <= '0;
         nc_ff        <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cl_ff        <= cl_in;
         used_ff      <= used_in;
         nc_ff        <= nc_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sym_ff        <= sym_in;
      rsp_sym_ff    <= rsp_sym_in;
      rsp_code_ff   <= rsp_code_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule

@@ rtl/hcb_checker.sv @@
// port-level checker for the huffman code table builder, bound to the top level
// depends on hcb_pkg and huffman_code_table_builder_defines.svh
`include "huffman_code_table_builder_defines.svh"

module hcb_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [hcb_pkg::CODE_W-1:0]     rsp_code,
   input logic [hcb_pkg::LEN_W-1:0]      rsp_code_length,
   input logic [hcb_pkg::STATUS_W-1:0]   rsp_status
);

   `HCB_ASSERT(a_rsp_hold, (rsp_valid && !rsp_ready) |=> rsp_valid, "response dropped while stalled")
   `HCB_ASSERT(a_rsp_stable, (rsp_valid && !rsp_ready) |=> ($stable(rsp_code) && $stable(rsp_status)), "response changed while stalled")
   `HCB_ASSERT(a_err_zero, (rsp_valid && rsp_status != hcb_pkg::STATUS_OK) |-> (rsp_code == '0 && rsp_code_length == '0 && (rsp_status == hcb_pkg::STATUS_TOO_MANY || rsp_status == hcb_pkg::STATUS_OVERFLOW)), "bad error entry")
   `HCB_ASSERT(a_ok_fits, (rsp_valid && rsp_status == hcb_pkg::STATUS_OK) |-> (rsp_code_length != '0 && rsp_code_length <= hcb_pkg::LEN_W'(hcb_pkg::MAX_CODE_LENGTH) && (rsp_code >> rsp_code_length) == '0), "code does not fit its length")

endmodule

bind huffman_code_table_builder hcb_checker u_hcb_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_code        (rsp_ch.code),
   .rsp_code_length (rsp_ch.code_length),
   .rsp_status      (rsp_ch.status)
);
